/* sv/rgbhsl_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and constants for the RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int CH_BITS = 12;
  // Divider datapath width: holds 6*c, which is below 6*2^CH_BITS.
  localparam int DIV_W   = CH_BITS + 3;

  localparam logic [CH_BITS-1:0] CH_FULL  = '1;
  // Hue of a gray pixel: 0.6 of a turn.
  localparam logic [CH_BITS-1:0] HUE_GRAY = CH_BITS'((3 * (1 << CH_BITS)) / 5);

  typedef logic [CH_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha_in;
  } pix_in_t;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t lightness;
    chan_t alpha_out;
  } pix_out_t;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

  // Fields that bypass the dividers.
  typedef struct packed {
    logic  gray;
    chan_t lightness;
    chan_t alpha;
  } side_t;

  // Fractional divide request: rem < dvs, low bits are shifted in MSB first.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    chan_t            low;
  } div_req_t;

endpackage

/* sv/rgbhsl_prep.sv */
// ----------------------------------------------------------------------------
// rgbhsl_prep
// Two-stage front end: max/min selection, then chroma, divider operands,
// lightness and the gray flag.
// ----------------------------------------------------------------------------
module rgbhsl_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  rgbhsl_pkg::pix_in_t  pix,
  output logic                 out_vld,
  output rgbhsl_pkg::div_req_t hue_req,
  output rgbhsl_pkg::div_req_t sat_req,
  output rgbhsl_pkg::side_t    side
);
  import rgbhsl_pkg::*;

  // stage 1
  logic     vld1_r;
  chan_t    r1_r, g1_r, b1_r, a1_r, mx1_r, mn1_r;
  max_sel_t sel1_r;
  max_sel_t sel_nxt;
  chan_t    mx_nxt, mn_nxt;

  // stage 2
  logic     vld2_r;
  div_req_t hue_r, sat_r;
  side_t    side_r;

  logic [CH_BITS-1:0]   c;
  logic [CH_BITS:0]     sum;
  logic signed [CH_BITS:0] d;
  logic [DIV_W-1:0]     kc, c6, t;
  logic [CH_BITS-1:0]   den;
  logic [2*CH_BITS-1:0] x;
  div_req_t             hue_nxt, sat_nxt;
  side_t                side_nxt;

  // Ties go to red, then green.
  always_comb begin
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sel_nxt = MAX_RED;
      mx_nxt  = pix.red;
    end else if (pix.green >= pix.blue) begin
      sel_nxt = MAX_GREEN;
      mx_nxt  = pix.green;
    end else begin
      sel_nxt = MAX_BLUE;
      mx_nxt  = pix.blue;
    end
    mn_nxt = (pix.red <= pix.green) ? pix.red : pix.green;
    if (pix.blue < mn_nxt) mn_nxt = pix.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    r1_r   <= pix.red;
    g1_r   <= pix.green;
    b1_r   <= pix.blue;
    a1_r   <= pix.alpha_in;
    mx1_r  <= mx_nxt;
    mn1_r  <= mn_nxt;
    sel1_r <= sel_nxt;
  end

  always_comb begin
    c   = mx1_r - mn1_r;
    sum = {1'b0, mx1_r} + {1'b0, mn1_r};
    c6  = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
    case (sel1_r)
      MAX_RED: begin
        d  = $signed({1'b0, g1_r}) - $signed({1'b0, b1_r});
        // negative hue wraps by a full turn: add 6c to the numerator
        kc = d[CH_BITS] ? c6 : '0;
      end
      MAX_GREEN: begin
        d  = $signed({1'b0, b1_r}) - $signed({1'b0, r1_r});
        kc = {2'b00, c, 1'b0};
      end
      MAX_BLUE: begin
        d  = $signed({1'b0, r1_r}) - $signed({1'b0, g1_r});
        kc = {1'b0, c, 2'b00};
      end
      default: begin
        d  = '0;
        kc = '0;
      end
    endcase
    t = kc + {{(DIV_W-CH_BITS-1){d[CH_BITS]}}, d};

    if (sum <= {1'b0, CH_FULL}) den = sum[CH_BITS-1:0];
    else                        den = CH_BITS'({CH_FULL, 1'b0} - sum);

    // c * CH_FULL
    x = {c, {CH_BITS{1'b0}}} - {{CH_BITS{1'b0}}, c};

    hue_nxt.rem = t;
    hue_nxt.dvs = c6;
    hue_nxt.low = '0;
    sat_nxt.rem = DIV_W'(x[2*CH_BITS-1:CH_BITS]);
    sat_nxt.dvs = DIV_W'(den);
    sat_nxt.low = x[CH_BITS-1:0];

    side_nxt.gray      = (c == '0);
    side_nxt.lightness = sum[CH_BITS:1];
    side_nxt.alpha     = a1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    hue_r  <= hue_nxt;
    sat_r  <= sat_nxt;
    side_r <= side_nxt;
  end

  assign out_vld = vld2_r;
  assign hue_req = hue_r;
  assign sat_req = sat_r;
  assign side    = side_r;

endmodule

/* sv/rgbhsl_div.sv */
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, CH_BITS stages.
// Gives floor((rem * 2^CH_BITS + low) / dvs) for rem < dvs.
// ----------------------------------------------------------------------------
module rgbhsl_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  rgbhsl_pkg::div_req_t req,
  output logic                 out_vld,
  output rgbhsl_pkg::chan_t    quo
);
  import rgbhsl_pkg::*;

  logic [CH_BITS-1:0] vld_r;
  logic [DIV_W-1:0]   rem_r [CH_BITS];
  logic [DIV_W-1:0]   dvs_r [CH_BITS];
  chan_t              low_r [CH_BITS];
  chan_t              quo_r [CH_BITS];

  for (genvar s = 0; s < CH_BITS; s++) begin : g_stage
    logic [DIV_W-1:0] rem_i, dvs_i, rem_nxt;
    chan_t            low_i, quo_i;
    logic             vld_i;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_i = req.rem;
      assign dvs_i = req.dvs;
      assign low_i = req.low;
      assign quo_i = '0;
      assign vld_i = in_vld;
    end else begin : g_rest
      assign rem_i = rem_r[s-1];
      assign dvs_i = dvs_r[s-1];
      assign low_i = low_r[s-1];
      assign quo_i = quo_r[s-1];
      assign vld_i = vld_r[s-1];
    end

    always_comb begin
      trial   = {rem_i, low_i[CH_BITS-1]};
      diff    = trial - {1'b0, dvs_i};
      ge      = (trial >= {1'b0, dvs_i});
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
      rem_r[s] <= rem_nxt;
      dvs_r[s] <= dvs_i;
      low_r[s] <= {low_i[CH_BITS-2:0], 1'b0};
      quo_r[s] <= {quo_i[CH_BITS-2:0], ge};
    end
  end

  assign out_vld = vld_r[CH_BITS-1];
  assign quo     = quo_r[CH_BITS-1];

endmodule

/* sv/rgb_to_hsl_convert.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert
// RGBA to HSLA pixel converter, fully pipelined, integer arithmetic.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock: busy is always low, so a request is taken
// on every cycle that start is high. Each request yields exactly one result,
// shown for one cycle with out_strobe, in request order. A request passes
// through two front-end stages, then the hue and saturation dividers (one
// quotient bit per stage, run side by side), then one output register. The
// receiver cannot stall the block and must take every strobed result. There
// is no start-up sweep after reset.
module rgb_to_hsl_convert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rgbhsl_pkg::pix_in_t  in_pix,
  output logic                 out_strobe,
  output rgbhsl_pkg::pix_out_t out_pix
);
  import rgbhsl_pkg::*;

  logic     accept;
  logic     prep_vld, hue_vld, sat_vld;
  div_req_t hue_req, sat_req;
  side_t    side;
  chan_t    hue_q, sat_q;
  side_t    side_r [CH_BITS];

  logic     out_strobe_r;
  pix_out_t out_pix_r, out_pix_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rgbhsl_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .pix     (in_pix),
    .out_vld (prep_vld),
    .hue_req (hue_req),
    .sat_req (sat_req),
    .side    (side)
  );

  rgbhsl_div u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (prep_vld),
    .req     (hue_req),
    .out_vld (hue_vld),
    .quo     (hue_q)
  );

  rgbhsl_div u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (prep_vld),
    .req     (sat_req),
    .out_vld (sat_vld),
    .quo     (sat_q)
  );

  // bypass fields ride alongside the divider stages
  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < CH_BITS; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  always_comb begin
    out_pix_nxt.hue        = side_r[CH_BITS-1].gray ? HUE_GRAY : hue_q;
    out_pix_nxt.saturation = side_r[CH_BITS-1].gray ? '0 : sat_q;
    out_pix_nxt.lightness  = side_r[CH_BITS-1].lightness;
    out_pix_nxt.alpha_out  = side_r[CH_BITS-1].alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= hue_vld & sat_vld;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_pix    = out_pix_r;

endmodule
